/* src/hrpc_pkg.sv */
// ----------------------------------------------------------------------------
// hrpc_pkg
// Types, constants and the level-to-duty scaling shared by the heater ramp
// PWM controller.
// ----------------------------------------------------------------------------
package hrpc_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 11;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SETPOINT       = 3'd0,
    REG_DEADBAND       = 3'd1,
    REG_MANUAL_MASK    = 3'd2,
    REG_MANUAL_LEVEL_A = 3'd3,
    REG_MANUAL_LEVEL_B = 3'd4,
    REG_PRESENT_MASK   = 3'd5
  } reg_index_t;

  localparam logic        [7:0]  LEVEL_MAX  = 8'd200;
  localparam logic        [7:0]  STEP_UP    = 8'd10;
  localparam logic        [7:0]  STEP_DOWN  = 8'd6;
  localparam logic        [7:0]  STEP_DECAY = 8'd1;
  localparam logic        [10:0] DUTY_MAX   = 11'd1023;
  localparam logic signed [11:0] TEMP_LOW   = -12'sd500;
  localparam logic signed [11:0] TEMP_HIGH  = 12'sd800;

  localparam logic signed [10:0] TARGET_RESET  = 11'sd375;
  localparam logic        [7:0]  HYST_RESET    = 8'd5;
  localparam logic        [1:0]  PRESENT_RESET = 2'b11;

  // ceil(2^20 / 25): exact floor division by 25 for inputs below 2^15
  localparam logic [15:0] RECIP_25 = 16'd41944;

  typedef struct packed {
    logic signed [10:0] setpoint;
    logic        [7:0]  deadband;
    logic        [1:0]  manual_mask;
    logic        [7:0]  manual_level_a;
    logic        [7:0]  manual_level_b;
    logic        [1:0]  present_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] level;
    logic       fault;
  } dem_res_t;

  // floor(level * 1023 / 200), saturated at 1023
  function automatic logic [9:0] level_to_duty(input logic [7:0] level);
    logic [17:0] scaled;
    logic [14:0] eighths;
    logic [30:0] prod;
    logic [10:0] quot;
    begin
      scaled  = {level, 10'b0} - {10'b0, level};
      eighths = scaled[17:3];
      prod    = {16'b0, eighths} * {15'b0, RECIP_25};
      quot    = prod[30:20];
      level_to_duty = (quot > DUTY_MAX) ? DUTY_MAX[9:0] : quot[9:0];
    end
  endfunction

endpackage

/* src/hrpc_if.sv */
// ----------------------------------------------------------------------------
// hrpc_if
// Valid/ready channels for temperature samples and heater results.
// ----------------------------------------------------------------------------
interface hrpc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

interface hrpc_result_if;
  logic       valid;
  logic       ready;
  logic [9:0] duty_a;
  logic       write_a;
  logic [9:0] duty_b;
  logic       write_b;
  logic [7:0] demand;
  logic       sensor_fault;

  modport source (output valid, output duty_a, output write_a, output duty_b,
                  output write_b, output demand, output sensor_fault, input ready);
  modport sink   (input valid, input duty_a, input write_a, input duty_b,
                  input write_b, input demand, input sensor_fault, output ready);
endinterface

/* src/hrpc_demand.sv */
// ----------------------------------------------------------------------------
// hrpc_demand
// Range check, dead-band compare and the demand level state register.
// ----------------------------------------------------------------------------
module hrpc_demand
  import hrpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic signed [11:0] temperature,
  input  logic               upd_en,
  output dem_res_t           res
);

  logic [7:0]         demand_level;
  logic [7:0]         demand_level_next;
  logic               fault;
  logic signed [13:0] diff;
  logic signed [13:0] hyst;
  logic [8:0]         level_up;

  always_comb begin
    fault    = (temperature < TEMP_LOW) || (temperature > TEMP_HIGH);
    diff     = 14'(cfg.setpoint) - 14'(temperature);
    hyst     = $signed({6'b0, cfg.deadband});
    level_up = {1'b0, demand_level} + {1'b0, STEP_UP};
    priority if (fault) begin
      demand_level_next = '0;
    end else if (diff > hyst) begin
      demand_level_next = (level_up > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : level_up[7:0];
    end else if (diff < -hyst) begin
      demand_level_next = (demand_level > STEP_DOWN) ? demand_level - STEP_DOWN : '0;
    end else begin
      demand_level_next = (demand_level > STEP_DECAY) ? demand_level - STEP_DECAY : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      demand_level <= '0;
    end else if (upd_en) begin
      demand_level <= demand_level_next;
    end
  end

  assign res.level = demand_level_next;
  assign res.fault = fault;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    demand_level <= LEVEL_MAX)
    else $error("demand level above maximum");

  a_level_moves_on_update: assert property (@(posedge clk) disable iff (rst)
    demand_level != $past(demand_level) |-> $past(upd_en) || $past(rst))
    else $error("demand level changed without an update");

endmodule

/* src/hrpc_duty.sv */
// ----------------------------------------------------------------------------
// hrpc_duty
// Per-channel level selection and scaling to a 10-bit PWM duty.
// ----------------------------------------------------------------------------
module hrpc_duty
  import hrpc_pkg::*;
(
  input  logic [7:0] auto_level,
  input  logic [7:0] manual_level,
  input  logic       manual_sel,
  input  logic       present,
  input  logic       fault,
  output logic [9:0] duty,
  output logic       write
);

  logic [7:0] level;

  always_comb begin
    level = manual_sel ? manual_level : auto_level;
    write = present && !fault;
    duty  = write ? level_to_duty(level) : '0;
  end

endmodule

/* src/heater_ramp_pwm_controller_core.sv */
// ----------------------------------------------------------------------------
// heater_ramp_pwm_controller_core
// Ramps a heater demand level from temperature samples and drives two PWM
// duty channels from it or from manual levels.
//
//   channel   dir   handshake      payload
//   sample    in    valid/ready    temperature (12b signed, 0.1 C)
//   result    out   valid/ready    duty_a, write_a, duty_b, write_b, demand,
//                                  sensor_fault
//   cfg       in    cfg_we         cfg_index (3b), cfg_data (11b)
//
// One sample per cycle sustained while the result is not stalled; the sample
// is captured in the input register and then loaded into the result register,
// from which the result leaves. The demand register closes its update loop at
// the input register stage, so back-to-back samples need no bubble.
// Synchronous reset clears the valid flags, the demand level and loads the
// register defaults. A stalled result holds both stages; sample.ready stays
// high while the result register is empty or being drained.
// ----------------------------------------------------------------------------
module heater_ramp_pwm_controller_core
  import hrpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  hrpc_sample_if.sink              sample,
  hrpc_result_if.source            result,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t               cfg;
  logic               s1_valid;
  logic signed [11:0] s1_temp;
  logic               out_valid;
  logic               adv;
  logic               s1_move;
  dem_res_t           dem;
  logic [9:0]         duty_a;
  logic               write_a;
  logic [9:0]         duty_b;
  logic               write_b;

  logic [9:0] res_duty_a;
  logic       res_write_a;
  logic [9:0] res_duty_b;
  logic       res_write_b;
  logic [7:0] res_demand;
  logic       res_fault;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint       <= TARGET_RESET;
      cfg.deadband       <= HYST_RESET;
      cfg.manual_mask    <= '0;
      cfg.manual_level_a <= '0;
      cfg.manual_level_b <= '0;
      cfg.present_mask   <= PRESENT_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SETPOINT:       cfg.setpoint       <= $signed(cfg_data[10:0]);
        REG_DEADBAND:       cfg.deadband       <= cfg_data[7:0];
        REG_MANUAL_MASK:    cfg.manual_mask    <= cfg_data[1:0];
        REG_MANUAL_LEVEL_A: cfg.manual_level_a <= cfg_data[7:0];
        REG_MANUAL_LEVEL_B: cfg.manual_level_b <= cfg_data[7:0];
        REG_PRESENT_MASK:   cfg.present_mask   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign adv          = !out_valid || result.ready;
  assign s1_move      = s1_valid && adv;
  assign sample.ready = !s1_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_temp <= sample.temperature;
    end
  end

  hrpc_demand u_demand (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .temperature (s1_temp),
    .upd_en      (s1_move),
    .res         (dem)
  );

  hrpc_duty u_duty_a (
    .auto_level   (dem.level),
    .manual_level (cfg.manual_level_a),
    .manual_sel   (cfg.manual_mask[0]),
    .present      (cfg.present_mask[0]),
    .fault        (dem.fault),
    .duty         (duty_a),
    .write        (write_a)
  );

  hrpc_duty u_duty_b (
    .auto_level   (dem.level),
    .manual_level (cfg.manual_level_b),
    .manual_sel   (cfg.manual_mask[1]),
    .present      (cfg.present_mask[1]),
    .fault        (dem.fault),
    .duty         (duty_b),
    .write        (write_b)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_duty_a  <= duty_a;
      res_write_a <= write_a;
      res_duty_b  <= duty_b;
      res_write_b <= write_b;
      res_demand  <= dem.level;
      res_fault   <= dem.fault;
    end
  end

  assign result.valid        = out_valid;
  assign result.duty_a       = res_duty_a;
  assign result.write_a      = res_write_a;
  assign result.duty_b       = res_duty_b;
  assign result.write_b      = res_write_b;
  assign result.demand       = res_demand;
  assign result.sensor_fault = res_fault;

  a_fault_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_fault |-> !res_write_a && !res_write_b && (res_demand == '0))
    else $error("fault result carries channel writes or demand");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_write_a || res_duty_a == '0) && (res_write_b || res_duty_b == '0))
    else $error("duty nonzero on a channel that is not written");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> sample.ready)
    else $error("sample request blocked with empty result register");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> out_valid)
    else $error("request lost between input and result register");

endmodule
